/* design/pec15_frame_generator_checker_assert.svh */
// assertion macros shared by the design files
`ifndef PEC15_FRAME_GENERATOR_CHECKER_ASSERT_SVH
`define PEC15_FRAME_GENERATOR_CHECKER_ASSERT_SVH

// property checked on every clock edge outside reset
`define PEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in one cycle implies consequence in the next
`define PEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pec15fgc_pkg.sv */
`timescale 1ns / 1ps

package pec15fgc_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] PEC_POLY = 16'h4599;
    localparam logic [15:0] PEC_SEED = 16'd16;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CODE    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // configuration register indexes
    localparam logic REG_FRAME_MODE  = 1'b0;
    localparam logic REG_DATA_LENGTH = 1'b1;

    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       frame_mode;
        logic [6:0] data_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       code_ok;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]        cnt;
        t_result [MAX_RESULTS-1:0]   res;
    } t_push;

    // remainder contribution of one byte: eight polynomial shifts
    function automatic logic [15:0] pec_entry(input logic [7:0] addr);
        logic [15:0] r;
        r = {1'b0, addr, 7'b0};
        for (int k = 0; k < 8; k++) begin
            if (r[14]) begin
                r = (r << 1) ^ PEC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

endpackage

/* design/pec15_frame_generator_checker.sv */
`timescale 1ns / 1ps

// PEC-15 frame generator / checker (CRC-15, polynomial 0x4599, seed 16)
// input channel: i_in_valid / o_in_ready carry i_data_byte and i_frame_start;
//   frame_start opens a frame and reseeds the remainder
// output channel: o_out_valid / i_out_ready carry o_out_byte, o_byte_kind,
//   o_code_ok and o_last; each input byte gives zero to three results
// config channel: i_cfg_valid / o_cfg_ready, index 0 frame_mode, index 1
//   data_length; always ready, write only while the block is idle
// generate mode echoes data bytes and appends the two code bytes after the
//   last one; check mode echoes data, takes two code bytes, gives a verdict
// latency: with the queue empty, a result is presented the cycle after its byte transfer
// throughput: one byte per cycle while the receiver takes a result every
//   cycle; after a byte that appends the code, o_in_ready stays low while
//   the two extra code bytes drain from the four-entry queue
// when the receiver stalls the queue fills and o_in_ready drops once fewer
//   than three entries are free, so a full burst of results always fits
// reset clears the queue, closes any open frame and restores the registers
//   to generate mode with six data bytes
module pec15_frame_generator_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_byte_kind,
    output logic       o_code_ok,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    pec15fgc_pkg::t_cfg   r_cfg;
    pec15fgc_pkg::t_push  push;
    logic                 in_accept;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_mode  <= 1'b0;
            r_cfg.data_length <= 7'd6;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pec15fgc_pkg::REG_FRAME_MODE:  r_cfg.frame_mode  <= i_cfg_data[0];
                pec15fgc_pkg::REG_DATA_LENGTH: r_cfg.data_length <= i_cfg_data;
            endcase
        end
    end

    pec15fgc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .i_cfg        (r_cfg),
        .o_push       (push)
    );

    pec15fgc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_push      (push),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_byte_kind (o_byte_kind),
        .o_code_ok   (o_code_ok),
        .o_last      (o_last)
    );

endmodule

/* design/pec15fgc_core.sv */
`timescale 1ns / 1ps
`include "pec15_frame_generator_checker_assert.svh"

module pec15fgc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_frame_start,
    input  pec15fgc_pkg::t_cfg   i_cfg,
    output pec15fgc_pkg::t_push  o_push
);

    logic [15:0]                     r_crc_rem, n_crc_rem;
    logic [pec15fgc_pkg::CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [7:0]                      r_received_high, n_received_high;
    logic                            r_frame_active, n_frame_active;
    logic                            r_code_phase, n_code_phase;

    logic [15:0]                     cur_rem;
    logic [pec15fgc_pkg::CNT_W-1:0]  cur_cnt;
    logic                            cur_phase;
    logic                            cur_active;
    logic [pec15fgc_pkg::CNT_W-1:0]  len;
    logic [15:0]                     upd_rem;
    logic [15:0]                     code_gen;
    logic [15:0]                     code_chk;
    logic [pec15fgc_pkg::CNT_W-1:0]  cnt_inc;

    // length clamped to one .. max frame bytes
    always_comb begin
        if (i_cfg.data_length == 7'd0) begin
            len = pec15fgc_pkg::CNT_W'(1);
        end else if (32'(i_cfg.data_length) > pec15fgc_pkg::MAX_FRAME_BYTES) begin
            len = pec15fgc_pkg::CNT_W'(pec15fgc_pkg::MAX_FRAME_BYTES);
        end else begin
            len = pec15fgc_pkg::CNT_W'(i_cfg.data_length);
        end
    end

    always_comb begin
        cur_rem    = r_crc_rem;
        cur_cnt    = r_byte_count;
        cur_phase  = r_code_phase;
        cur_active = r_frame_active;
        if (i_frame_start) begin
            cur_rem    = pec15fgc_pkg::PEC_SEED;
            cur_cnt    = '0;
            cur_phase  = 1'b0;
            cur_active = 1'b1;
        end

        upd_rem  = (cur_rem << 8) ^ pec15fgc_pkg::pec_entry(cur_rem[14:7] ^ i_data_byte);
        code_gen = {upd_rem[14:0], 1'b0};
        code_chk = {cur_rem[14:0], 1'b0};
        cnt_inc  = cur_cnt + pec15fgc_pkg::CNT_W'(1);

        n_crc_rem       = cur_rem;
        n_byte_count    = cur_cnt;
        n_code_phase    = cur_phase;
        n_frame_active  = cur_active;
        n_received_high = r_received_high;
        o_push          = '0;

        if (cur_active) begin
            if (cur_cnt < len) begin
                o_push.cnt    = pec15fgc_pkg::RES_CNT_W'(1);
                o_push.res[0] = '{i_data_byte, pec15fgc_pkg::KIND_DATA, 1'b0, 1'b0};
                n_crc_rem     = upd_rem;
                n_byte_count  = cnt_inc;
                if (cnt_inc == len && !i_cfg.frame_mode) begin
                    // last data byte in generate mode: append code, high byte first
                    o_push.cnt     = pec15fgc_pkg::RES_CNT_W'(3);
                    o_push.res[1]  = '{code_gen[15:8], pec15fgc_pkg::KIND_CODE, 1'b0, 1'b0};
                    o_push.res[2]  = '{code_gen[7:0], pec15fgc_pkg::KIND_CODE, 1'b0, 1'b1};
                    n_frame_active = 1'b0;
                end
            end else if (!cur_phase) begin
                n_received_high = i_data_byte;
                n_code_phase    = 1'b1;
            end else begin
                o_push.cnt     = pec15fgc_pkg::RES_CNT_W'(1);
                o_push.res[0]  = '{8'd0, pec15fgc_pkg::KIND_VERDICT,
                                   ({r_received_high, i_data_byte} == code_chk), 1'b1};
                n_code_phase   = 1'b0;
                n_frame_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_rem       <= pec15fgc_pkg::PEC_SEED;
            r_byte_count    <= '0;
            r_received_high <= '0;
            r_frame_active  <= 1'b0;
            r_code_phase    <= 1'b0;
        end else if (i_accept) begin
            r_crc_rem       <= n_crc_rem;
            r_byte_count    <= n_byte_count;
            r_received_high <= n_received_high;
            r_frame_active  <= n_frame_active;
            r_code_phase    <= n_code_phase;
        end
    end

    `PEC_ASSERT(a_idle_quiet, (!r_frame_active && !i_frame_start) |-> (o_push.cnt == '0), "result outside a frame")
    `PEC_ASSERT(a_count_range, r_byte_count <= pec15fgc_pkg::CNT_W'(pec15fgc_pkg::MAX_FRAME_BYTES), "byte count above frame limit")
    `PEC_ASSERT(a_code_pair, (o_push.cnt == pec15fgc_pkg::RES_CNT_W'(3)) |-> (o_push.res[2].last && o_push.res[1].byte_kind == pec15fgc_pkg::KIND_CODE && !i_cfg.frame_mode), "bad appended code pair")

endmodule

/* design/pec15fgc_outq.sv */
`timescale 1ns / 1ps
`include "pec15_frame_generator_checker_assert.svh"

module pec15fgc_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  pec15fgc_pkg::t_push  i_push,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_byte_kind,
    output logic                 o_code_ok,
    output logic                 o_last
);

    pec15fgc_pkg::t_result               r_mem [pec15fgc_pkg::Q_DEPTH];
    logic [pec15fgc_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [pec15fgc_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [pec15fgc_pkg::Q_CNT_W-1:0]    r_count, n_count;
    logic [pec15fgc_pkg::Q_CNT_W-1:0]    push_cnt;
    logic                                pop;
    pec15fgc_pkg::t_result               head;

    // room for a full burst of results before taking an item
    assign o_in_ready  = r_count <= pec15fgc_pkg::Q_CNT_W'(pec15fgc_pkg::Q_DEPTH
                                                             - pec15fgc_pkg::MAX_RESULTS);
    assign o_out_valid = r_count != '0;
    assign pop         = o_out_valid && i_out_ready;
    assign push_cnt    = i_accept ? pec15fgc_pkg::Q_CNT_W'(i_push.cnt) : '0;

    assign head        = r_mem[r_rd_ptr];
    assign o_out_byte  = head.out_byte;
    assign o_byte_kind = head.byte_kind;
    assign o_code_ok   = head.code_ok;
    assign o_last      = head.last;

    always_comb begin
        n_wr_ptr = r_wr_ptr + pec15fgc_pkg::Q_PTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + pec15fgc_pkg::Q_PTR_W'(pop);
        n_count  = r_count + push_cnt - pec15fgc_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < pec15fgc_pkg::MAX_RESULTS; i++) begin
            if (i_accept && (pec15fgc_pkg::RES_CNT_W'(i) < i_push.cnt)) begin
                r_mem[r_wr_ptr + pec15fgc_pkg::Q_PTR_W'(i)] <= i_push.res[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `PEC_ASSERT(a_no_overflow, r_count <= pec15fgc_pkg::Q_CNT_W'(pec15fgc_pkg::Q_DEPTH), "result queue overflow")
    `PEC_ASSERT(a_burst_room, (i_accept && i_push.cnt != '0) |-> (r_count <= pec15fgc_pkg::Q_CNT_W'(pec15fgc_pkg::Q_DEPTH - pec15fgc_pkg::MAX_RESULTS)), "push without room")
    `PEC_ASSERT_NEXT(a_empty_stays, !o_out_valid && !(i_accept && i_push.cnt != '0), !o_out_valid, "result appeared without a push")

endmodule

/* tb/pec15_frame_generator_checker_tb.sv */
`timescale 1ns / 1ps

module pec15_frame_generator_checker_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 230;

    // tracks the frame state and the results each byte should produce
    class pec_frame_tracker;
        bit        mode_check;
        bit [6:0]  length_reg;
        bit [14:0] remainder;
        bit [6:0]  data_count;
        bit [7:0]  code_high;
        bit        frame_open;
        bit        code_pending;
        pec15fgc_pkg::t_result due_results[$];
        int        errors;

        function void clear();
            mode_check   = 1'b0;
            length_reg   = 7'd6;
            remainder    = 15'(pec15fgc_pkg::PEC_SEED);
            data_count   = '0;
            code_high    = '0;
            frame_open   = 1'b0;
            code_pending = 1'b0;
            due_results.delete();
            errors       = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] value);
            if (idx == pec15fgc_pkg::REG_FRAME_MODE) begin
                mode_check = value[0];
            end else begin
                length_reg = value;
            end
        endfunction

        function int frame_length();
            if (length_reg == 7'd0) begin
                return 1;
            end
            if (int'(length_reg) > pec15fgc_pkg::MAX_FRAME_BYTES) begin
                return pec15fgc_pkg::MAX_FRAME_BYTES;
            end
            return int'(length_reg);
        endfunction

        // msb-first serial division, one bit per step
        function bit [14:0] fold_byte(bit [14:0] rem, bit [7:0] b);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb  = rem[14] ^ b[i];
                rem = rem << 1;
                if (fb) begin
                    rem ^= 15'(pec15fgc_pkg::PEC_POLY);
                end
            end
            return rem;
        endfunction

        function bit [15:0] wire_code();
            return {remainder, 1'b0};
        endfunction

        function void push(bit [7:0] b, logic [1:0] kind, bit ok, bit fin);
            due_results.push_back(pec15fgc_pkg::t_result'{out_byte: b, byte_kind: kind,
                                                          code_ok: ok, last: fin});
        endfunction

        // returns 1 when the byte belongs to an open frame
        function bit take_byte(bit [7:0] b, bit start);
            int        len;
            bit [15:0] code;
            len = frame_length();
            if (start) begin
                remainder    = 15'(pec15fgc_pkg::PEC_SEED);
                data_count   = '0;
                code_pending = 1'b0;
                frame_open   = 1'b1;
            end
            if (!frame_open) begin
                return 1'b0;
            end
            if (int'(data_count) < len) begin
                push(b, pec15fgc_pkg::KIND_DATA, 1'b0, 1'b0);
                remainder  = fold_byte(remainder, b);
                data_count = data_count + 7'd1;
                if (int'(data_count) == len && !mode_check) begin
                    code = wire_code();
                    push(code[15:8], pec15fgc_pkg::KIND_CODE, 1'b0, 1'b0);
                    push(code[7:0], pec15fgc_pkg::KIND_CODE, 1'b0, 1'b1);
                    frame_open = 1'b0;
                end
                return 1'b1;
            end
            // past the data bytes: received code, high byte first
            if (!code_pending) begin
                code_high    = b;
                code_pending = 1'b1;
                return 1'b1;
            end
            code = wire_code();
            push(8'h00, pec15fgc_pkg::KIND_VERDICT, {code_high, b} == code, 1'b1);
            code_pending = 1'b0;
            frame_open   = 1'b0;
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task match_result(pec15fgc_pkg::t_result got);
            pec15fgc_pkg::t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result byte %h kind %0d",
                                 got.out_byte, got.byte_kind));
                return;
            end
            want = due_results.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            end
            if (got.byte_kind !== want.byte_kind) begin
                report($sformatf("byte_kind %0d, want %0d", got.byte_kind, want.byte_kind));
            end
            if (got.code_ok !== want.code_ok) begin
                report($sformatf("code_ok %b, want %b", got.code_ok, want.code_ok));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = '0;
    logic       i_frame_start = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_byte_kind;
    logic       o_code_ok;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = 1'b0;
    logic [6:0] i_cfg_data = '0;

    pec_frame_tracker tracker;
    bit  calm;
    int  consumed;
    int  cycles;
    int  hold_left;

    pec15_frame_generator_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_kind   (o_byte_kind),
        .o_code_ok     (o_code_ok),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pec15_frame_generator_checker_tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 7'($urandom_range(1, 6));
        end
        if (r < 78) begin
            return 7'($urandom_range(7, 20));
        end
        if (r < 85) begin
            return 7'd0;
        end
        if (r < 90) begin
            return 7'd1;
        end
        if (r < 94) begin
            return 7'd64;
        end
        if (r < 97) begin
            return 7'($urandom_range(65, 126));
        end
        return 7'd127;
    endfunction

    // receiver: random stalls, none while calm
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 35) begin
                hold_left = pick_gap();
            end
        end
    end

    // values are stable at the falling edge and transfer at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.match_result(pec15fgc_pkg::t_result'{out_byte: o_out_byte,
                                                         byte_kind: o_byte_kind,
                                                         code_ok: o_code_ok,
                                                         last: o_last});
        end
    end

    task send_byte(input logic [7:0] b, input logic start);
        int gap;
        bit ok;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= start;
        do begin
            @(negedge i_clk);
            ok = o_in_ready;
            @(posedge i_clk);
        end while (!ok);
        if (tracker.take_byte(b, start)) begin
            consumed++;
        end
    endtask

    task send_code(input logic [15:0] code);
        send_byte(code[15:8], 1'b0);
        send_byte(code[7:0], 1'b0);
    endtask

    task write_reg(input logic idx, input logic [6:0] value);
        bit ok;
        i_in_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        // a lone high code byte leaves nothing to wait on, so give it time
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    initial begin
        int        frames;
        int        r;
        int        len;
        bit [15:0] code;
        tracker = new();
        tracker.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: generate mode, six data bytes
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h7E, 1'b0);

        // check mode, good code then a bad one
        write_reg(pec15fgc_pkg::REG_FRAME_MODE, 7'd1);
        write_reg(pec15fgc_pkg::REG_DATA_LENGTH, 7'd2);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_code(tracker.wire_code());
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_code(tracker.wire_code() ^ 16'h0001);

        // mode flips to generate between the two code bytes
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        code = tracker.wire_code();
        send_byte(code[15:8], 1'b0);
        write_reg(pec15fgc_pkg::REG_FRAME_MODE, 7'd0);
        send_byte(code[7:0], 1'b0);

        // zero length acts as one
        write_reg(pec15fgc_pkg::REG_DATA_LENGTH, 7'd0);
        send_byte(8'hFF, 1'b1);
        write_reg(pec15fgc_pkg::REG_DATA_LENGTH, 7'd127);
        send_byte(8'h5A, 1'b1);
        repeat (63) send_byte(8'($urandom_range(0, 255)), 1'b0);

        while (consumed < RANDOM_BYTES) begin
            write_reg(pec15fgc_pkg::REG_FRAME_MODE, 7'($urandom_range(0, 1)));
            write_reg(pec15fgc_pkg::REG_DATA_LENGTH, pick_length());
            calm = ($urandom_range(0, 3) == 0);
            // carry on a frame left open under the old settings
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            frames = $urandom_range(2, 5);
            repeat (frames) begin
                r   = $urandom_range(0, 99);
                len = tracker.frame_length();
                if (r < 70) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    repeat (len - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    if (tracker.mode_check) begin
                        code = tracker.wire_code();
                        if ($urandom_range(0, 2) == 0) begin
                            code ^= 16'h0001 << $urandom_range(0, 15);
                        end
                        send_code(code);
                    end
                end else if (r < 82) begin
                    // cut short, sometimes restarted partway
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    repeat ($urandom_range(0, len)) begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    end
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
                    end
                end else begin
                    // data plus one trailing byte; in check mode the frame is left hanging
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.due_results.size() != 0) begin
            tracker.report("results still outstanding at end of run");
        end
        if (tracker.errors == 0) begin
            $display("pec15_frame_generator_checker_tb passed");
        end else begin
            $display("pec15_frame_generator_checker_tb failed");
        end
        $finish;
    end

endmodule

/* pec15_frame_generator_checker.f */
+incdir+design
design/pec15fgc_pkg.sv
design/pec15fgc_core.sv
design/pec15fgc_outq.sv
design/pec15_frame_generator_checker.sv
tb/pec15_frame_generator_checker_tb.sv
